/* rtl/i2s_clock_divider_search_assert.svh */
// Assertion macros shared by the search block and its divider.
`ifndef I2S_CLOCK_DIVIDER_SEARCH_ASSERT_SVH
`define I2S_CLOCK_DIVIDER_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define I2SCDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2SCDS_ASSERT_NEVER(lbl, expr, msg) \
    `I2SCDS_ASSERT(lbl, !(expr), msg)
`else
`define I2SCDS_ASSERT(lbl, prop, msg)
`define I2SCDS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/i2scds_pkg.sv */
`timescale 1ns / 1ps

package i2scds_pkg;

    localparam int unsigned DIV_W      = 25;
    localparam int unsigned CHOICE_MAX = 3;
    localparam int unsigned NUM_HALF_FRAME_CHOICES_DEF = 3;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [DIV_W-1:0] SRC_SLOW_HZ = 25'd16000000;
    localparam logic [DIV_W-1:0] SRC_FAST_HZ = 25'd32000000;
    localparam logic [6:0]       WORD_BITS   = 7'd16;
    localparam logic [6:0]       PAD_SAT_WS  = 7'd79;

    localparam logic [6:0] CHOICE_A_RST = 7'd16;
    localparam logic [6:0] CHOICE_B_RST = 7'd24;
    localparam logic [6:0] CHOICE_C_RST = 7'd32;

    localparam logic [1:0] CFG_FAST     = 2'd0;
    localparam logic [1:0] CFG_CHOICE_A = 2'd1;
    localparam logic [1:0] CFG_CHOICE_B = 2'd2;
    localparam logic [1:0] CFG_CHOICE_C = 2'd3;

    localparam logic [2:0] FMT_I2S       = 3'd0;
    localparam logic [2:0] FMT_PCM_SHORT = 3'd1;
    localparam logic [2:0] FMT_PCM_LONG  = 3'd2;
    localparam logic [2:0] FMT_LJ        = 3'd3;
    localparam logic [2:0] FMT_RJ        = 3'd4;

    localparam logic [1:0] MODE_PCM = 2'd0;
    localparam logic [1:0] MODE_LJ  = 2'd1;
    localparam logic [1:0] MODE_RJ  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_BAD_WORD   = 2'd2,
        ST_NO_RATE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  audio_format;
        logic [5:0]  sample_bits;
        logic        frame_slave;
        logic [19:0] frame_rate_hz;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  port_mode;
        logic        ws_start_falling;
        logic        sd_on_falling_sck;
        logic        ws_on_falling_sck;
        logic        ws_initial_level;
        logic        data_offset;
        logic        drives_clocks;
        logic [6:0]  clocks_per_half;
        logic [15:0] clock_divider;
        logic        source_select;
        logic [5:0]  pad_bits;
    } rsp_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] mode;
        logic       wsf;
        logic       sdf;
        logic       wsck;
        logic       wsinit;
        logic       offset;
    } fmt_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic fmt_t fmt_decode(logic [2:0] fmt);
        fmt_t f;
        f = '0;
        unique case (fmt) inside
            FMT_I2S:
            begin
                f.ok = 1'b1; f.mode = MODE_LJ; f.wsf = 1'b1; f.offset = 1'b1;
            end
            FMT_PCM_SHORT, FMT_PCM_LONG:
            begin
                f.ok = 1'b1; f.mode = MODE_PCM; f.sdf = 1'b1; f.wsck = 1'b1;
                f.wsinit = 1'b1; f.offset = 1'b1;
            end
            FMT_LJ:
            begin
                f.ok = 1'b1; f.mode = MODE_LJ;
            end
            FMT_RJ:
            begin
                f.ok = 1'b1; f.mode = MODE_RJ;
            end
            default:
            begin
                f.ok = 1'b0;
            end
        endcase
        return f;
    endfunction

endpackage

/* rtl/i2scds_if.sv */
`timescale 1ns / 1ps

interface i2scds_req_if;
    import i2scds_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2scds_rsp_if;
    import i2scds_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/i2s_clock_divider_search.sv */
`timescale 1ns / 1ps

// Serial audio port timing search. A request carries format, word size,
// frame-clock role and frame rate; one response returns the port timing flags
// and the best source clock, clocks-per-half-frame and divider. The search runs
// every candidate (up to three choices per source, 16 MHz then 32 MHz) through
// one shared 25-bit restoring divider that retires one quotient bit per cycle.
// Each candidate needs three divisions; a choice that is too short is skipped
// without any division, and a zero divider ends its candidate after two. Requests
// rejected on format, word size or a zero rate offer the response in the cycle
// after acceptance; a full search of up to six candidates offers it at its end.
// The request channel is not ready from acceptance until the response is taken.
// The user must write configuration only while idle; the block does not enforce it.

`include "i2s_clock_divider_search_assert.svh"

module i2s_clock_divider_search #(
    parameter int unsigned NUM_HALF_FRAME_CHOICES = i2scds_pkg::NUM_HALF_FRAME_CHOICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [i2scds_pkg::CFG_DATA_W-1:0] cfg_data,
    i2scds_req_if.sink                        req,
    i2scds_rsp_if.source                      rsp
);
    import i2scds_pkg::*;

    localparam int unsigned CHOICE_CNT =
        (NUM_HALF_FRAME_CHOICES > CHOICE_MAX) ? CHOICE_MAX : NUM_HALF_FRAME_CHOICES;
    localparam logic [1:0] IDX_LAST = 2'(CHOICE_CNT - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CAND   = 8'b0000_0010,
        S_NUM    = 8'b0000_0100,
        S_RND    = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_RSTART = 8'b0010_0000,
        S_REAL   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic             fast_reg;
    logic [6:0]       choice_reg [CHOICE_MAX];
    fmt_t             fmt_reg, fmt_next;
    logic             slave_reg, slave_next;
    logic [19:0]      rate_reg, rate_next;
    status_t          status_reg, status_next;
    logic             src_reg, src_next;
    logic [1:0]       idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [DIV_W-1:0] best_diff_reg, best_diff_next;
    logic [6:0]       best_ws_reg, best_ws_next;
    logic [15:0]      best_div_reg, best_div_next;
    logic             best_src_reg, best_src_next;
    logic [15:0]      cand_div_reg, cand_div_next;
    logic [DIV_W-1:0] prod_reg, prod_next;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [6:0]       ws_cur;
    logic [7:0]       two_ws;
    logic [DIV_W-1:0] clk_hz;
    logic [DIV_W-1:0] rate_ext;
    logic [DIV_W-1:0] diff;
    logic [23:0]      prod_w;
    logic             take;
    logic             found_now;
    fmt_t             fmt_in;
    logic             ok;
    logic [5:0]       pad;
    rsp_t             out_w;

    i2scds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign ws_cur   = choice_reg[idx_reg];
    assign two_ws   = {ws_cur, 1'b0};
    assign clk_hz   = src_reg ? SRC_FAST_HZ : SRC_SLOW_HZ;
    assign rate_ext = DIV_W'(rate_reg);
    assign prod_w   = cand_div_reg * two_ws;
    assign diff     = (div_rsp.quotient >= rate_ext) ? div_rsp.quotient - rate_ext
                                                    : rate_ext - div_rsp.quotient;
    assign take     = !found_reg || (diff < best_diff_reg);
    assign fmt_in   = fmt_decode(req.data.audio_format);

    always_comb
    begin
        state_next     = state_reg;
        fmt_next       = fmt_reg;
        slave_next     = slave_reg;
        rate_next      = rate_reg;
        status_next    = status_reg;
        src_next       = src_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_diff_next = best_diff_reg;
        best_ws_next   = best_ws_reg;
        best_div_next  = best_div_reg;
        best_src_next  = best_src_reg;
        cand_div_next  = cand_div_reg;
        prod_next      = prod_reg;
        div_req        = '0;
        found_now      = found_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    fmt_next   = fmt_in;
                    slave_next = req.data.frame_slave;
                    rate_next  = req.data.frame_rate_hz;
                    found_next = 1'b0;
                    src_next   = 1'b0;
                    idx_next   = '0;
                    if (!fmt_in.ok)
                    begin
                        status_next = ST_BAD_FORMAT;
                        state_next  = S_OUT;
                    end
                    else if (req.data.sample_bits != WORD_BITS[5:0])
                    begin
                        status_next = ST_BAD_WORD;
                        state_next  = S_OUT;
                    end
                    else if (req.data.frame_rate_hz == '0)
                    begin
                        status_next = ST_NO_RATE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_CAND;
                    end
                end
            end
            S_CAND:
            begin
                // skip choices too short for offset plus word
                if (ws_cur >= WORD_BITS + 7'(fmt_reg.offset))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = clk_hz;
                    div_req.divisor  = DIV_W'(two_ws);
                    state_next       = S_NUM;
                end
            end
            S_NUM:
            begin
                if (div_rsp.done)
                begin
                    // round to nearest
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient + DIV_W'(rate_reg[19:1]);
                    div_req.divisor  = rate_ext;
                    state_next       = S_RND;
                end
            end
            S_RND:
            begin
                if (div_rsp.done)
                begin
                    cand_div_next = div_rsp.quotient[15:0];
                    if (div_rsp.quotient[15:0] != '0)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = DIV_W'(prod_w);
                state_next = S_RSTART;
            end
            S_RSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = clk_hz;
                div_req.divisor  = prod_reg;
                state_next       = S_REAL;
            end
            S_REAL:
            begin
                if (div_rsp.done && take)
                begin
                    found_next     = 1'b1;
                    found_now      = 1'b1;
                    best_diff_next = diff;
                    best_ws_next   = ws_cur;
                    best_div_next  = cand_div_reg;
                    best_src_next  = src_reg;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the next candidate once this one is finished or skipped
        if ((state_reg == S_CAND && state_next == S_CAND)
            || (state_reg == S_RND && div_rsp.done && state_next == S_RND)
            || (state_reg == S_REAL && div_rsp.done))
        begin
            if (idx_reg != IDX_LAST)
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_CAND;
            end
            else if (!src_reg && fast_reg)
            begin
                src_next   = 1'b1;
                idx_next   = '0;
                state_next = S_CAND;
            end
            else
            begin
                status_next = found_now ? ST_OK : ST_NO_RATE;
                state_next  = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            src_reg       <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            fast_reg      <= 1'b1;
            choice_reg[0] <= CHOICE_A_RST;
            choice_reg[1] <= CHOICE_B_RST;
            choice_reg[2] <= CHOICE_C_RST;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            src_reg    <= src_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FAST:     fast_reg      <= cfg_data[0];
                    CFG_CHOICE_A: choice_reg[0] <= cfg_data;
                    CFG_CHOICE_B: choice_reg[1] <= cfg_data;
                    CFG_CHOICE_C: choice_reg[2] <= cfg_data;
                    default:      fast_reg      <= fast_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fmt_reg       <= fmt_next;
        slave_reg     <= slave_next;
        rate_reg      <= rate_next;
        best_diff_reg <= best_diff_next;
        best_ws_reg   <= best_ws_next;
        best_div_reg  <= best_div_next;
        best_src_reg  <= best_src_next;
        cand_div_reg  <= cand_div_next;
        prod_reg      <= prod_next;
    end

    assign ok  = (status_reg == ST_OK);
    assign pad = (best_ws_reg > PAD_SAT_WS) ? 6'd63 : 6'(best_ws_reg - WORD_BITS);

    always_comb
    begin
        out_w        = '0;
        out_w.status = status_reg;
        if (ok)
        begin
            out_w.port_mode         = fmt_reg.mode;
            out_w.ws_start_falling  = fmt_reg.wsf;
            out_w.sd_on_falling_sck = fmt_reg.sdf;
            out_w.ws_on_falling_sck = fmt_reg.wsck;
            out_w.ws_initial_level  = fmt_reg.wsinit;
            out_w.data_offset       = fmt_reg.offset;
            out_w.drives_clocks     = !slave_reg;
            out_w.clocks_per_half   = best_ws_reg;
            out_w.clock_divider     = best_div_reg;
            out_w.source_select     = best_src_reg;
            out_w.pad_bits          = (fmt_reg.mode == MODE_RJ) ? pad : 6'd0;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = out_w;

    `I2SCDS_ASSERT_NEVER(top_req_rsp_overlap, req.ready && rsp.valid, "request taken mid-search")
    `I2SCDS_ASSERT(top_ok_sane,
        rsp.valid && ok |-> best_div_reg != '0 && best_ws_reg >= WORD_BITS, "bad pick")
    `I2SCDS_ASSERT(top_fast_src,
        state_reg != S_IDLE && src_reg |-> fast_reg, "fast source not enabled")
    `I2SCDS_ASSERT_NEVER(top_div_start_idle,
        div_req.start && (state_reg == S_IDLE || state_reg == S_OUT), "stray divide")

endmodule

/* rtl/i2scds_div.sv */
`timescale 1ns / 1ps

`include "i2s_clock_divider_search_assert.svh"

module i2scds_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2scds_pkg::div_req_t req,
    output i2scds_pkg::div_rsp_t rsp
);
    import i2scds_pkg::*;

    localparam int unsigned CW = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    // one restoring step: shift in the next dividend bit, try to subtract
    assign trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = CW'(DIV_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `I2SCDS_ASSERT_NEVER(div_start_while_busy, req.start && busy_reg, "divider restarted mid-run")
    `I2SCDS_ASSERT(div_done_after_busy, done_reg |-> $past(busy_reg), "done without a run")
    `I2SCDS_ASSERT(div_rem_bound, done_reg && dsr_reg != '0 |-> rem_reg < dsr_reg, "bad remainder")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import i2scds_pkg::*;

    localparam int unsigned N_CHOICES   = 3;
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam int unsigned PHASE_ITEMS = 190;
    localparam int unsigned TAIL_CYCLES = 600;

    // format codes the block must reject
    localparam logic [2:0] FMT_BAD_LO = 3'd5;
    localparam logic [2:0] FMT_BAD_HI = 3'd7;
    localparam logic [5:0] WORD16     = WORD_BITS[5:0];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2scds_req_if req_ch ();
    i2scds_rsp_if rsp_ch ();

    i2s_clock_divider_search #(
        .NUM_HALF_FRAME_CHOICES(N_CHOICES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the block's registers
    logic       fast_en;
    logic [6:0] choice_cfg [3];

    req_t pending_reqs [$];
    rsp_t expected_timing [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    bit          long_hold_start;
    bit          req_fired;

    function automatic rsp_t predict_timing(req_t r);
        rsp_t        res;
        logic [1:0]  mode;
        logic        wsf, sdf, wsck, wsinit;
        int unsigned offs, rate, src_hz, ws, num, div, achieved, diff;
        int unsigned best_diff, best_ws, best_div, n_src, n_ch, pad;
        bit          found, best_src;
        res = '0;
        mode = MODE_PCM;
        wsf = 1'b0;
        sdf = 1'b0;
        wsck = 1'b0;
        wsinit = 1'b0;
        offs = 0;
        case (r.audio_format)
            FMT_I2S:
            begin
                mode = MODE_LJ;
                wsf = 1'b1;
                offs = 1;
            end
            FMT_PCM_SHORT, FMT_PCM_LONG:
            begin
                mode = MODE_PCM;
                sdf = 1'b1;
                wsck = 1'b1;
                wsinit = 1'b1;
                offs = 1;
            end
            FMT_LJ: mode = MODE_LJ;
            FMT_RJ: mode = MODE_RJ;
            default:
            begin
                res.status = ST_BAD_FORMAT;
                return res;
            end
        endcase
        if (r.sample_bits != WORD16)
        begin
            res.status = ST_BAD_WORD;
            return res;
        end

        rate = r.frame_rate_hz;
        n_src = fast_en ? 2 : 1;
        n_ch = (N_CHOICES > 3) ? 3 : N_CHOICES;
        found = 1'b0;
        best_diff = 0;
        best_ws = 0;
        best_div = 0;
        best_src = 1'b0;
        if (rate != 0)
        begin
            for (int s = 0; s < n_src; s++)
            begin
                src_hz = (s != 0) ? SRC_FAST_HZ : SRC_SLOW_HZ;
                for (int c = 0; c < n_ch; c++)
                begin
                    ws = choice_cfg[c];
                    if (ws < offs + 16)
                        continue;
                    num = src_hz / (ws * 2);
                    div = ((num + rate / 2) / rate) & 32'hFFFF;
                    if (div == 0)
                        continue;
                    achieved = src_hz / div / (ws * 2);
                    diff = (achieved >= rate) ? achieved - rate : rate - achieved;
                    // keep the earlier pair on a tie
                    if (!found || diff < best_diff)
                    begin
                        found = 1'b1;
                        best_diff = diff;
                        best_ws = ws;
                        best_div = div;
                        best_src = (s != 0);
                    end
                end
            end
        end
        if (!found)
        begin
            res.status = ST_NO_RATE;
            return res;
        end

        pad = 0;
        if (mode == MODE_RJ)
            pad = (best_ws - 16 > 63) ? 63 : best_ws - 16;

        res.status = ST_OK;
        res.port_mode = mode;
        res.ws_start_falling = wsf;
        res.sd_on_falling_sck = sdf;
        res.ws_on_falling_sck = wsck;
        res.ws_initial_level = wsinit;
        res.data_offset = offs[0];
        res.drives_clocks = ~r.frame_slave;
        res.clocks_per_half = best_ws[6:0];
        res.clock_divider = best_div[15:0];
        res.source_select = best_src;
        res.pad_bits = pad[5:0];
        return res;
    endfunction

    function automatic req_t make_req(logic [2:0] fmt, logic [5:0] bits, logic slave,
                                      logic [19:0] rate);
        req_t r;
        r.audio_format = fmt;
        r.sample_bits = bits;
        r.frame_slave = slave;
        r.frame_rate_hz = rate;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r.frame_slave = 1'($urandom_range(1));
        if ($urandom_range(99) < 15)
        begin
            // noise: any format, any word size, any rate
            r.audio_format = 3'($urandom_range(7));
            r.sample_bits = 6'($urandom_range(63));
            r.frame_rate_hz = 20'($urandom_range(20'hFFFFF));
            return r;
        end
        r.audio_format = 3'($urandom_range(FMT_RJ));
        r.sample_bits = WORD16;
        pick = $urandom_range(99);
        if (pick < 55)
            r.frame_rate_hz = 20'($urandom_range(192000, 8000));
        else if (pick < 80)
            r.frame_rate_hz = 20'($urandom_range(20'hFFFFF, 1));
        else if (pick < 90)
            r.frame_rate_hz = 20'($urandom_range(64, 1));
        else if (pick < 95)
            r.frame_rate_hz = '0;
        else
            r.frame_rate_hz = 20'($urandom_range(20'hFFFFF, 900000));
        return r;
    endfunction

    function automatic logic [6:0] random_choice();
        if ($urandom_range(99) < 75)
            return 7'($urandom_range(64, 16));
        return 7'($urandom_range(127));
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FAST:     fast_en = val[0];
            CFG_CHOICE_A: choice_cfg[0] = val;
            CFG_CHOICE_B: choice_cfg[1] = val;
            CFG_CHOICE_C: choice_cfg[2] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(logic fast, logic [6:0] a, logic [6:0] b, logic [6:0] c);
        write_reg(CFG_FAST, {6'd0, fast});
        write_reg(CFG_CHOICE_A, a);
        write_reg(CFG_CHOICE_B, b);
        write_reg(CFG_CHOICE_C, c);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_timing.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_fired)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_ch.data <= pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            req_fired = 1'b0;
        end
    end

    // response ready, with an optional long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_start)
            begin
                hold_left = HOLD_CYCLES;
                long_hold_start = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each request, check each response
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_timing.push_back(predict_timing(req_ch.data));
                req_fired = 1'b1;
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                got = rsp_ch.data;
                if (expected_timing.size() == 0)
                begin
                    $error("response with no request pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_timing.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("port_mode", want.port_mode, got.port_mode);
                    check_field("ws_start_falling", want.ws_start_falling,
                                got.ws_start_falling);
                    check_field("sd_on_falling_sck", want.sd_on_falling_sck,
                                got.sd_on_falling_sck);
                    check_field("ws_on_falling_sck", want.ws_on_falling_sck,
                                got.ws_on_falling_sck);
                    check_field("ws_initial_level", want.ws_initial_level,
                                got.ws_initial_level);
                    check_field("data_offset", want.data_offset, got.data_offset);
                    check_field("drives_clocks", want.drives_clocks, got.drives_clocks);
                    check_field("clocks_per_half", want.clocks_per_half,
                                got.clocks_per_half);
                    check_field("clock_divider", want.clock_divider, got.clock_divider);
                    check_field("source_select", want.source_select, got.source_select);
                    check_field("pad_bits", want.pad_bits, got.pad_bits);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FAST;
        cfg_data = '0;
        fast_en = 1'b1;
        choice_cfg[0] = CHOICE_A_RST;
        choice_cfg[1] = CHOICE_B_RST;
        choice_cfg[2] = CHOICE_C_RST;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        hold_left = 0;
        long_hold_start = 1'b0;
        req_fired = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every format, word size and rate extremes at reset settings
        pending_reqs.push_back(make_req(FMT_I2S, WORD16, 1'b0, 20'd48000));
        pending_reqs.push_back(make_req(FMT_PCM_SHORT, WORD16, 1'b1, 20'd44100));
        pending_reqs.push_back(make_req(FMT_PCM_LONG, WORD16, 1'b0, 20'd8000));
        pending_reqs.push_back(make_req(FMT_LJ, WORD16, 1'b1, 20'd96000));
        pending_reqs.push_back(make_req(FMT_RJ, WORD16, 1'b0, 20'd192000));
        pending_reqs.push_back(make_req(FMT_BAD_LO, WORD16, 1'b0, 20'd48000));
        // bad format wins over bad word size
        pending_reqs.push_back(make_req(FMT_BAD_HI, 6'd8, 1'b1, 20'd48000));
        pending_reqs.push_back(make_req(FMT_I2S, 6'd0, 1'b0, 20'd48000));
        pending_reqs.push_back(make_req(FMT_LJ, 6'd24, 1'b1, 20'd48000));
        pending_reqs.push_back(make_req(FMT_PCM_LONG, 6'd32, 1'b0, 20'd48000));
        pending_reqs.push_back(make_req(FMT_RJ, 6'd63, 1'b1, 20'd48000));
        pending_reqs.push_back(make_req(FMT_I2S, WORD16, 1'b0, 20'd0));
        pending_reqs.push_back(make_req(FMT_LJ, WORD16, 1'b0, 20'd1));
        pending_reqs.push_back(make_req(FMT_PCM_SHORT, WORD16, 1'b1, 20'hFFFFF));
        pending_reqs.push_back(make_req(FMT_I2S, WORD16, 1'b1, 20'd1000000));
        pending_reqs.push_back(make_req(FMT_RJ, WORD16, 1'b1, 20'd11025));
        wait_drained();

        // zero choice, pad saturation, zero divider on every pair
        apply_config(1'b0, 7'd0, 7'd127, 7'd80);
        pending_reqs.push_back(make_req(FMT_RJ, WORD16, 1'b0, 20'd48000));
        pending_reqs.push_back(make_req(FMT_RJ, WORD16, 1'b1, 20'd8000));
        pending_reqs.push_back(make_req(FMT_I2S, WORD16, 1'b0, 20'hFFFFF));
        pending_reqs.push_back(make_req(FMT_PCM_SHORT, WORD16, 1'b0, 20'd32000));
        pending_reqs.push_back(make_req(FMT_LJ, WORD16, 1'b1, 20'd1));
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_config(1'b1, CHOICE_A_RST, CHOICE_B_RST, CHOICE_C_RST);
                1: apply_config(1'b0, 7'd1, 7'd64, 7'd17);
                2: apply_config(1'b1, 7'd64, 7'd64, 7'd64);
                3: apply_config(1'b1, 7'd17, 7'd16, 7'd127);
                default: apply_config(1'($urandom_range(1)), random_choice(), random_choice(),
                                      random_choice());
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            // hold responses off while requests keep coming
            if (ph == 2)
                long_hold_start = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_reqs.push_back(random_request());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_timing.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
